// ----- rtl/hkd_pkg.sv -----
// Shared types, constants and keystroke tables of the Hangul keystroke decomposer.
package hkd_pkg;

   localparam int CODE_W      = 16;
   localparam int KEY_W       = 16;
   localparam int CHAR_W      = 8;
   localparam int MAX_KEYS    = 5;
   localparam int KEY_IDX_W   = $clog2(MAX_KEYS);
   localparam int COUNT_W     = $clog2(MAX_KEYS + 1);
   localparam int JAMO_W      = 5;
   localparam int SYL_OFS_W   = 14;
   localparam int Q28_W       = 9;
   localparam int QUEUE_DEPTH = 2;

   // Code unit ranges
   localparam logic [CODE_W-1:0] SYL_FIRST  = 16'hAC00;
   localparam logic [CODE_W-1:0] SYL_LAST   = 16'hD7A3;
   localparam logic [CODE_W-1:0] CONS_FIRST = 16'h3131;
   localparam logic [CODE_W-1:0] CONS_LAST  = 16'h314E;
   localparam logic [CODE_W-1:0] VOW_FIRST  = 16'h314F;
   localparam logic [CODE_W-1:0] VOW_LAST   = 16'h3163;

   // Reciprocals: floor(s / 28) and floor(q / 21) over the syllable range
   localparam logic [15:0] RECIP_28       = 16'd37450;
   localparam int          RECIP_28_SHIFT = 20;
   localparam int          PROD28_W       = SYL_OFS_W + 16;
   localparam logic [11:0] RECIP_21       = 12'd3121;
   localparam int          RECIP_21_SHIFT = 16;
   localparam int          PROD21_W       = Q28_W + 12;

   localparam logic [CHAR_W-1:0] NO_KEY = 8'h00;

   typedef enum logic [1:0] {
      CLS_SYLLABLE,
      CLS_CONS,
      CLS_VOWEL,
      CLS_OTHER
   } hkd_class_type;

   typedef struct packed {
      logic [MAX_KEYS-1:0][KEY_W-1:0] keys;
      logic [COUNT_W-1:0]             count;
   } hkd_run_type;

   function automatic logic [CHAR_W-1:0] initial_key(input logic [JAMO_W-1:0] idx);
      logic [CHAR_W-1:0] k;
      case (idx)
         5'd0:    k = "r";
         5'd1:    k = "R";
         5'd2:    k = "s";
         5'd3:    k = "e";
         5'd4:    k = "E";
         5'd5:    k = "f";
         5'd6:    k = "a";
         5'd7:    k = "q";
         5'd8:    k = "Q";
         5'd9:    k = "t";
         5'd10:   k = "T";
         5'd11:   k = "d";
         5'd12:   k = "w";
         5'd13:   k = "W";
         5'd14:   k = "c";
         5'd15:   k = "z";
         5'd16:   k = "x";
         5'd17:   k = "v";
         5'd18:   k = "g";
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

   function automatic logic [2*CHAR_W-1:0] vowel_pair(input logic [JAMO_W-1:0] idx);
      logic [2*CHAR_W-1:0] p;
      case (idx)
         5'd0:    p = {"k", NO_KEY};
         5'd1:    p = {"o", NO_KEY};
         5'd2:    p = {"i", NO_KEY};
         5'd3:    p = {"O", NO_KEY};
         5'd4:    p = {"j", NO_KEY};
         5'd5:    p = {"p", NO_KEY};
         5'd6:    p = {"u", NO_KEY};
         5'd7:    p = {"P", NO_KEY};
         5'd8:    p = {"h", NO_KEY};
         5'd9:    p = {"h", "k"};
         5'd10:   p = {"h", "o"};
         5'd11:   p = {"h", "l"};
         5'd12:   p = {"y", NO_KEY};
         5'd13:   p = {"n", NO_KEY};
         5'd14:   p = {"n", "j"};
         5'd15:   p = {"n", "p"};
         5'd16:   p = {"n", "l"};
         5'd17:   p = {"b", NO_KEY};
         5'd18:   p = {"m", NO_KEY};
         5'd19:   p = {"m", "l"};
         5'd20:   p = {"l", NO_KEY};
         default: p = {NO_KEY, NO_KEY};
      endcase
      return p;
   endfunction

   function automatic logic [2*CHAR_W-1:0] final_pair(input logic [JAMO_W-1:0] idx);
      logic [2*CHAR_W-1:0] p;
      case (idx)
         5'd1:    p = {"r", NO_KEY};
         5'd2:    p = {"R", NO_KEY};
         5'd3:    p = {"r", "t"};
         5'd4:    p = {"s", NO_KEY};
         5'd5:    p = {"s", "w"};
         5'd6:    p = {"s", "g"};
         5'd7:    p = {"e", NO_KEY};
         5'd8:    p = {"f", NO_KEY};
         5'd9:    p = {"f", "r"};
         5'd10:   p = {"f", "a"};
         5'd11:   p = {"f", "q"};
         5'd12:   p = {"f", "t"};
         5'd13:   p = {"f", "x"};
         5'd14:   p = {"f", "v"};
         5'd15:   p = {"f", "g"};
         5'd16:   p = {"a", NO_KEY};
         5'd17:   p = {"q", NO_KEY};
         5'd18:   p = {"q", "t"};
         5'd19:   p = {"t", NO_KEY};
         5'd20:   p = {"T", NO_KEY};
         5'd21:   p = {"d", NO_KEY};
         5'd22:   p = {"w", NO_KEY};
         5'd23:   p = {"c", NO_KEY};
         5'd24:   p = {"z", NO_KEY};
         5'd25:   p = {"x", NO_KEY};
         5'd26:   p = {"v", NO_KEY};
         5'd27:   p = {"g", NO_KEY};
         default: p = {NO_KEY, NO_KEY};
      endcase
      return p;
   endfunction

   function automatic logic [2*CHAR_W-1:0] cons_pair(input logic [JAMO_W-1:0] idx);
      logic [2*CHAR_W-1:0] p;
      case (idx)
         5'd0:    p = {"r", NO_KEY};
         5'd1:    p = {"R", NO_KEY};
         5'd2:    p = {"r", "t"};
         5'd3:    p = {"s", NO_KEY};
         5'd4:    p = {"s", "w"};
         5'd5:    p = {"s", "g"};
         5'd6:    p = {"e", NO_KEY};
         5'd7:    p = {"E", NO_KEY};
         5'd8:    p = {"f", NO_KEY};
         5'd9:    p = {"f", "r"};
         5'd10:   p = {"f", "a"};
         5'd11:   p = {"f", "q"};
         5'd12:   p = {"f", "t"};
         5'd13:   p = {"f", "x"};
         5'd14:   p = {"f", "v"};
         5'd15:   p = {"f", "g"};
         5'd16:   p = {"a", NO_KEY};
         5'd17:   p = {"q", NO_KEY};
         5'd18:   p = {"Q", NO_KEY};
         5'd19:   p = {"q", "t"};
         5'd20:   p = {"t", NO_KEY};
         5'd21:   p = {"T", NO_KEY};
         5'd22:   p = {"d", NO_KEY};
         5'd23:   p = {"w", NO_KEY};
         5'd24:   p = {"W", NO_KEY};
         5'd25:   p = {"c", NO_KEY};
         5'd26:   p = {"z", NO_KEY};
         5'd27:   p = {"x", NO_KEY};
         5'd28:   p = {"v", NO_KEY};
         5'd29:   p = {"g", NO_KEY};
         default: p = {NO_KEY, NO_KEY};
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/hkd_if.sv -----
// Valid/ready channel interfaces for code units in and keystrokes out.
interface hkd_req_if import hkd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink (input valid, input code_unit, output ready);
endinterface

interface hkd_rsp_if import hkd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_code;
   logic             last_of_run;

   modport source (output valid, output key_code, output last_of_run, input ready);
   modport sink (input valid, input key_code, input last_of_run, output ready);
endinterface

// ----- rtl/hangul_to_keystroke_decomposer.sv -----
// Top level of the Hangul syllable to two-set keyboard keystroke decomposer.
//
// Usage:
//   req_ch carries one UTF-16 code unit per item (valid/ready). rsp_ch returns
//   the keystrokes for it, one item per key, with last_of_run set on the final
//   key of each code unit. A precomposed syllable gives 2 to 5 keys, a lone
//   compatibility jamo 1 or 2, any other unit passes through as one item.
// Path: the first key of a code unit passes the classify/divide register, then
//   the queue write, then the output register before it is valid.
// Throughput: one key per cycle while rsp_ch.ready is high; a code unit gives
//   1 to 5 keys. The output register is the bottleneck; the front end takes a
//   new item every cycle while the run queue is not full.
// Reset: synchronous, active high; empties the run queue and drops any pending
//   key. No table needs initialization.
// Stall: when rsp_ch.ready is low the current key holds; the queue fills and
//   then req_ch.ready drops until the back end drains a run.
module hangul_to_keystroke_decomposer import hkd_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   hkd_req_if.sink   req_ch,
   hkd_rsp_if.source rsp_ch
);

   // Front to queue
   logic        push;
   hkd_run_type push_data;
   logic        queue_full;

   // Queue to back
   logic        head_valid;
   hkd_run_type head;
   logic        pop;

   // Classify, divide by 588/28 and build the run of keys
   hkd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // Decouple the front from output stalls
   hkd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Serialize each run onto the output, one key per cycle while rsp_ch.ready is high
   hkd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- rtl/hkd_front.sv -----
// Front end: accept code units, classify, split syllables and build keystroke runs.
module hkd_front import hkd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hkd_req_if.sink     req_ch,
   output logic        push,
   output hkd_run_type push_data,
   input  logic        queue_full
);

   logic                   accept;
   logic                   a_valid_ff, a_valid_in;
   logic [CODE_W-1:0]      code_ff;
   hkd_class_type          cls_ff, cls_w;
   logic [Q28_W-1:0]       q28_ff, q28_w;
   logic [JAMO_W-1:0]      fin_ff, fin_w;
   logic [JAMO_W-1:0]      jidx_ff, jidx_w;
   logic [SYL_OFS_W-1:0]   s_w;
   logic [PROD28_W-1:0]    prod28_w;
   logic [PROD21_W-1:0]    prod21_w;
   logic [JAMO_W-1:0]      ini_w, med_w, vow_idx_w;
   logic [2*CHAR_W-1:0]    vowel_w, final_w, cons_w;
   logic [COUNT_W-1:0]     n;
   hkd_run_type            run;

   assign req_ch.ready = !a_valid_ff || !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = a_valid_ff && !queue_full;

   // Classify and take the first division step (by 28) on the incoming unit
   always_comb begin
      if (req_ch.code_unit inside {[SYL_FIRST:SYL_LAST]}) begin
         cls_w = CLS_SYLLABLE;
      end else if (req_ch.code_unit inside {[CONS_FIRST:CONS_LAST]}) begin
         cls_w = CLS_CONS;
      end else if (req_ch.code_unit inside {[VOW_FIRST:VOW_LAST]}) begin
         cls_w = CLS_VOWEL;
      end else begin
         cls_w = CLS_OTHER;
      end
   end

   assign s_w      = SYL_OFS_W'(req_ch.code_unit - SYL_FIRST);
   assign prod28_w = PROD28_W'(s_w) * PROD28_W'(RECIP_28);
   assign q28_w    = prod28_w[RECIP_28_SHIFT +: Q28_W];
   assign fin_w    = JAMO_W'(s_w - (SYL_OFS_W'(q28_w) * SYL_OFS_W'(28)));
   assign jidx_w   = (cls_w == CLS_CONS) ? JAMO_W'(req_ch.code_unit - CONS_FIRST)
                                         : JAMO_W'(req_ch.code_unit - VOW_FIRST);

   assign a_valid_in = accept ? 1'b1 : (push ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= req_ch.code_unit;
         cls_ff  <= cls_w;
         q28_ff  <= q28_w;
         fin_ff  <= fin_w;
         jidx_ff <= jidx_w;
      end
   end

   // Second division step (by 21) gives initial and medial
   assign prod21_w  = PROD21_W'(q28_ff) * PROD21_W'(RECIP_21);
   assign ini_w     = prod21_w[RECIP_21_SHIFT +: JAMO_W];
   assign med_w     = JAMO_W'(q28_ff - (Q28_W'(ini_w) * Q28_W'(21)));
   assign vow_idx_w = (cls_ff == CLS_SYLLABLE) ? med_w : jidx_ff;
   assign vowel_w   = vowel_pair(vow_idx_w);
   assign final_w   = final_pair(fin_ff);
   assign cons_w    = cons_pair(jidx_ff);

   always_comb begin
      run = '0;
      n   = '0;
      case (cls_ff)
         CLS_SYLLABLE: begin
            run.keys[0] = KEY_W'(initial_key(ini_w));
            run.keys[1] = KEY_W'(vowel_w[2*CHAR_W-1:CHAR_W]);
            n = COUNT_W'(2);
            if (vowel_w[CHAR_W-1:0] != NO_KEY) begin
               run.keys[2] = KEY_W'(vowel_w[CHAR_W-1:0]);
               n = COUNT_W'(3);
            end
            if (fin_ff != '0) begin
               run.keys[KEY_IDX_W'(n)] = KEY_W'(final_w[2*CHAR_W-1:CHAR_W]);
               n = n + COUNT_W'(1);
               if (final_w[CHAR_W-1:0] != NO_KEY) begin
                  run.keys[KEY_IDX_W'(n)] = KEY_W'(final_w[CHAR_W-1:0]);
                  n = n + COUNT_W'(1);
               end
            end
         end
         CLS_CONS, CLS_VOWEL: begin
            if (cls_ff == CLS_CONS) begin
               run.keys[0] = KEY_W'(cons_w[2*CHAR_W-1:CHAR_W]);
               run.keys[1] = KEY_W'(cons_w[CHAR_W-1:0]);
               n = (cons_w[CHAR_W-1:0] != NO_KEY) ? COUNT_W'(2) : COUNT_W'(1);
            end else begin
               run.keys[0] = KEY_W'(vowel_w[2*CHAR_W-1:CHAR_W]);
               run.keys[1] = KEY_W'(vowel_w[CHAR_W-1:0]);
               n = (vowel_w[CHAR_W-1:0] != NO_KEY) ? COUNT_W'(2) : COUNT_W'(1);
            end
         end
         default: begin
            run.keys[0] = code_ff;
            n = COUNT_W'(1);
         end
      endcase
      run.count = n;
   end

   assign push_data = run;

endmodule

// ----- rtl/hkd_queue.sv -----
// Small FIFO of keystroke runs between the front and back ends.
module hkd_queue import hkd_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  hkd_run_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output hkd_run_type head
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   hkd_run_type       mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/hkd_back.sv -----
// Back end: step through the head run and send one keystroke per cycle unless rsp_ch stalls.
module hkd_back import hkd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  hkd_run_type head,
   output logic        pop,
   hkd_rsp_if.source   rsp_ch
);

   logic                 load;
   logic                 is_last;
   logic [KEY_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]     key_ff;
   logic                 last_ff;

   assign load    = head_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign is_last = (COUNT_W'(idx_ff) == head.count - COUNT_W'(1));
   assign pop     = load && is_last;

   assign idx_in       = load ? (is_last ? '0 : idx_ff + KEY_IDX_W'(1)) : idx_ff;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff  <= head.keys[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.key_code    = key_ff;
   assign rsp_ch.last_of_run = last_ff;

`ifndef SYNTH
   // Keys of one run leave back to back: the run stays at the queue head
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ch.ready && !last_ff) |=> rsp_valid_ff)
      else $error("keystroke run broken before its last key");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (COUNT_W'(idx_ff) < head.count))
      else $error("key index beyond run length");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0))
      else $error("key index not cleared with empty queue");
`endif

endmodule

// ----- sim/keystroke_run_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard that predicts the keystroke run of each accepted code unit and checks every key.
module keystroke_run_checker import hkd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [CODE_W-1:0] req_code_unit,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [KEY_W-1:0]  rsp_key_code,
   input  logic              rsp_last_of_run,
   output int                fail_count,
   output int                pending_keys
);

   localparam int  SYLS_PER_LEAD  = 588;
   localparam int  SYLS_PER_VOWEL = 28;
   localparam byte NO_KEY_CHAR    = " ";

   typedef struct packed {
      logic [KEY_W-1:0] key_code;
      logic             last_of_run;
   } keystroke_type;

   // Key tables of the two-set layout, one character per jamo index; blank = no key.
   string lead_keys    = "rRseEfaqQtTdwWczxvg";
   string vowel_first  = "koiOjpuPhhhhynnnnbmml";
   string vowel_second = "         kol  jpl  l ";
   string tail_first   = " rRrssseffffffffaqqtTdwczxvg";
   string tail_second  = "   t wg  raqtxvg  t         ";
   string cons_first   = "rRrssseEffffffffaqQqtTdwWczxvg";
   string cons_second  = "  t wg   raqtxvg   t          ";

   keystroke_type    expected_keys[$];
   logic [KEY_W-1:0] run_keys[$];
   int               mismatches  = 0;
   int               outstanding = 0;

   assign fail_count   = mismatches;
   assign pending_keys = outstanding;

   function automatic void append_key(input logic [KEY_W-1:0] key);
      run_keys.insert(run_keys.size(), key);
   endfunction

   function automatic void expect_key(input keystroke_type stroke);
      expected_keys.insert(expected_keys.size(), stroke);
   endfunction

   function automatic void append_jamo(input byte first, input byte second);
      append_key({8'h00, first});
      if (second != NO_KEY_CHAR)
         append_key({8'h00, second});
   endfunction

   function automatic void predict_keystrokes(input logic [CODE_W-1:0] unit);
      int unsigned offset;
      int unsigned lead;
      int unsigned vowel;
      int unsigned tail;
      run_keys.delete();
      if (unit >= SYL_FIRST && unit <= SYL_LAST) begin
         offset = unit - SYL_FIRST;
         lead   = offset / SYLS_PER_LEAD;
         vowel  = (offset % SYLS_PER_LEAD) / SYLS_PER_VOWEL;
         tail   = offset % SYLS_PER_VOWEL;
         append_key({8'h00, lead_keys[lead]});
         append_jamo(vowel_first[vowel], vowel_second[vowel]);
         if (tail != 0)
            append_jamo(tail_first[tail], tail_second[tail]);
      end else if (unit >= CONS_FIRST && unit <= CONS_LAST) begin
         offset = unit - CONS_FIRST;
         append_jamo(cons_first[offset], cons_second[offset]);
      end else if (unit >= VOW_FIRST && unit <= VOW_LAST) begin
         offset = unit - VOW_FIRST;
         append_jamo(vowel_first[offset], vowel_second[offset]);
      end else begin
         append_key(unit);
      end
      foreach (run_keys[i])
         expect_key('{run_keys[i], i == run_keys.size() - 1});
   endfunction

   always @(posedge clock) begin
      keystroke_type oldest;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_keystrokes(req_code_unit);
         if (rsp_valid && rsp_ready) begin
            if (expected_keys.size() == 0) begin
               $error("key_code: expected nothing, got %h", rsp_key_code);
               mismatches++;
            end else begin
               oldest = expected_keys.pop_front();
               if (rsp_key_code !== oldest.key_code) begin
                  $error("key_code: expected %h, got %h", oldest.key_code, rsp_key_code);
                  mismatches++;
               end
               if (rsp_last_of_run !== oldest.last_of_run) begin
                  $error("last_of_run: expected %b, got %b",
                         oldest.last_of_run, rsp_last_of_run);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= expected_keys.size();
   end

endmodule

// ----- sim/hangul_to_keystroke_decomposer_test.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, code-unit stimulus and keystroke back-pressure for the decomposer.
module hangul_to_keystroke_decomposer_test import hkd_pkg::*; ();

   localparam int  HOLD_OFF_CYCLES = 80;
   localparam int  DRAIN_CYCLES    = 10;
   localparam int  IDLE_PERCENT    = 14;
   localparam time RUN_LIMIT       = 2_000_000;

   logic clock = 1'b0;
   logic reset;

   hkd_req_if req_ch ();
   hkd_rsp_if rsp_ch ();

   // Sender idling is read only by the stimulus; the rest crosses processes and moves by NBA.
   bit sender_jitter = 1'b1;
   bit sink_jitter;
   int hold_requests = 0;
   int holds_done    = 0;
   int fail_count;
   int pending_keys;

   // Edges of every range, the rieul compound finals ending in q and t, the longest runs,
   // surrogates, the Hangul filler and all-zero / all-one code units.
   logic [CODE_W-1:0] directed_units [24] = '{
      16'h0000, 16'hFFFF, 16'h0041, 16'h5555,
      16'hABFF, 16'hAC00, 16'hAC01, 16'hAC0B, 16'hAC0C, 16'hACFF, 16'hAE26,
      16'hD7A3, 16'hD7A4,
      16'h3130, 16'h3131, 16'h3133, 16'h314E,
      16'h314F, 16'h3158, 16'h3163, 16'h3164,
      16'hD800, 16'hDFFF, 16'hAAAA
   };

   always #6 clock = ~clock;

   hangul_to_keystroke_decomposer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   keystroke_run_checker run_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_code_unit   (req_ch.code_unit),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_key_code    (rsp_ch.key_code),
      .rsp_last_of_run (rsp_ch.last_of_run),
      .fail_count      (fail_count),
      .pending_keys    (pending_keys)
   );

   // Offer one code unit and return at the edge that accepts it. Valid stays high on return,
   // so the next call either idles it or replaces the payload, never both in one step.
   task automatic offer_unit(input logic [CODE_W-1:0] unit);
      if (sender_jitter) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid     <= 1'b1;
      req_ch.code_unit <= unit;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Weight toward syllables, where the longest runs live; keep a share of arbitrary units
   // so pass-through and all 16 bits get exercised.
   function automatic logic [CODE_W-1:0] random_unit();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50)
         return CODE_W'($urandom_range(SYL_LAST, SYL_FIRST));
      else if (pick < 65)
         return CODE_W'($urandom_range(CONS_LAST, CONS_FIRST));
      else if (pick < 75)
         return CODE_W'($urandom_range(VOW_LAST, VOW_FIRST));
      else
         return CODE_W'($urandom_range(16'hFFFF, 0));
   endfunction

   // Receiver: random stalls, a quiet stretch, and one long hold-off counted here.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (sink_jitter) begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.code_unit <= '0;
      reset            <= 1'b1;
      sink_jitter      <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners first.
      foreach (directed_units[i])
         offer_unit(directed_units[i]);

      // Random traffic with idling on both sides.
      repeat (130) offer_unit(random_unit());

      // Quiet stretch: back-to-back items, receiver always ready.
      sender_jitter = 1'b0;
      sink_jitter  <= 1'b0;
      repeat (100) offer_unit(random_unit());

      // Hold off the receiver while the sender keeps pushing, so the run queue fills
      // and the input stalls.
      sink_jitter   <= 1'b1;
      hold_requests <= hold_requests + 1;
      repeat (40) offer_unit(random_unit());

      sender_jitter = 1'b1;
      repeat (86) offer_unit(random_unit());
      req_ch.valid <= 1'b0;

      // Let the last expectation land in the pending count, then drain.
      @(posedge clock);
      while (pending_keys != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: abort a hung run.
   initial begin
      #RUN_LIMIT;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
